FILE: rtl/dndc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dndc_pkg
// Types, calendar constants and month-length lookup shared by the day number
// to date converter.
// ----------------------------------------------------------------------------
package dndc_pkg;

  localparam int unsigned DnW  = 22;
  localparam int unsigned YrW  = 14;
  localparam int unsigned MonW = 4;
  localparam int unsigned DayW = 5;
  localparam int unsigned DoyW = 9;
  localparam int unsigned AccW = 26;

  // day spans of the Gregorian cycle
  localparam logic [DnW-1:0] DAYS_400Y = 22'd146097;
  localparam logic [DnW-1:0] DAYS_100Y = 22'd36524;
  localparam logic [DnW-1:0] DAYS_4Y   = 22'd1461;
  localparam logic [DnW-1:0] DAYS_1Y   = 22'd365;

  localparam logic [DnW-1:0] YEARS_400 = 22'd400;
  localparam logic [DnW-1:0] YEARS_100 = 22'd100;
  localparam logic [DnW-1:0] YEARS_4   = 22'd4;
  localparam logic [DnW-1:0] YEARS_1   = 22'd1;

  localparam logic [AccW-1:0] DN_MAX   = 26'h3FFFFF;

  localparam logic             FUNC_DN2DATE = 1'b0;
  localparam logic             FUNC_DATE2DN = 1'b1;

  localparam logic [MonW-1:0]  MON_FEB = 4'd2;
  localparam logic [MonW-1:0]  MON_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y400,
    ST_Y100,
    ST_Y4,
    ST_Y1,
    ST_MON,
    ST_SUM
  } state_e;

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    if (m == MON_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/day_number_date_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// day_number_date_converter
// Converts between a running day number (day 1 = 1 Jan, year 1) and a
// proleptic Gregorian date, in either direction, with one shared
// subtract/compare unit stepping through 400-, 100-, 4- and 1-year spans
// and then months.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// request   in         start_i / busy_o     func_i, day_number_i, in_year_i,
//                                           in_month_i, in_day_i
// result    out        done_o (strobe)      out_day_number_o, out_year_o,
//                                           out_month_o, out_day_o,
//                                           day_of_year_o, is_leap_o, status_o
//
// A beat is taken when start_i is high and busy_o is low. The shared unit
// works through the 400-year, century, four-year, year and month steps in
// turn, with an exit step closing each span; date to day number adds a final
// summing step. Inputs rejected on entry finish without leaving idle. done_o
// pulses for one cycle with the result and the receiver cannot hold it off;
// the next beat may be taken in that same cycle. Reset clears the sequencer
// and the strobe only.
// ----------------------------------------------------------------------------
module day_number_date_converter
  import dndc_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire logic            func_i,
  input  wire logic [DnW-1:0]  day_number_i,
  input  wire logic [YrW-1:0]  in_year_i,
  input  wire logic [MonW-1:0] in_month_i,
  input  wire logic [DayW-1:0] in_day_i,
  output logic                 done_o,
  output logic [DnW-1:0]       out_day_number_o,
  output logic [YrW-1:0]       out_year_o,
  output logic [MonW-1:0]      out_month_o,
  output logic [DayW-1:0]      out_day_o,
  output logic [DoyW-1:0]      day_of_year_o,
  output logic                 is_leap_o,
  output logic                 status_o
);

  // last valid day number: days before year MAX_YEAR+1
  localparam logic [31:0] DN_LIMIT = 32'(MAX_YEAR * 365 + MAX_YEAR / 4
                                         - MAX_YEAR / 100 + MAX_YEAR / 400);
  localparam logic [16:0] MAX_YEAR_W = 17'(MAX_YEAR);

  state_e          state_q, state_d;
  logic [DnW-1:0]  r_q, r_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [1:0]      c_q, c_d;
  logic [4:0]      q4_q, q4_d;
  logic [1:0]      y1_q, y1_d;
  logic [MonW-1:0] m_q, m_d;
  logic [DoyW-1:0] doy_q, doy_d;
  logic            leap_q, leap_d;

  logic            func_q, func_d;
  logic [DnW-1:0]  dn_q, dn_d;
  logic [YrW-1:0]  yr_q, yr_d;
  logic [MonW-1:0] mo_q, mo_d;
  logic [DayW-1:0] d_q, d_d;

  logic            done_q;
  logic [DnW-1:0]  res_dn_q, res_dn_d;
  logic [YrW-1:0]  res_yr_q, res_yr_d;
  logic [MonW-1:0] res_mo_q, res_mo_d;
  logic [DayW-1:0] res_day_q, res_day_d;
  logic [DoyW-1:0] res_doy_q, res_doy_d;
  logic            res_leap_q, res_leap_d;
  logic            res_err_q, res_err_d;
  logic            fin;

  logic [DnW-1:0]  take;
  logic [AccW-1:0] give;
  logic [DnW:0]    diff;
  logic            ge;
  logic [AccW-1:0] sum;
  logic [DayW-1:0] mlen_cur;
  logic            leap_now;

  assign mlen_cur = month_len(m_q, leap_q);
  // year = n + 1 is leap when n mod 4 == 3, unless n mod 100 == 99 and n mod 400 != 399
  assign leap_now = (y1_q == 2'd3) && ((q4_q != 5'd24) || (c_q == 2'd3));

  always_comb begin
    state_d   = state_q;
    r_d       = r_q;
    acc_d     = acc_q;
    c_d       = c_q;
    q4_d      = q4_q;
    y1_d      = y1_q;
    m_d       = m_q;
    doy_d     = doy_q;
    leap_d    = leap_q;
    func_d    = func_q;
    dn_d      = dn_q;
    yr_d      = yr_q;
    mo_d      = mo_q;
    d_d       = d_q;
    fin       = 1'b0;
    res_dn_d  = '0;
    res_yr_d  = '0;
    res_mo_d  = '0;
    res_day_d = '0;
    res_doy_d = '0;
    res_leap_d = 1'b0;
    res_err_d = 1'b0;

    // shared step unit: what comes off r and what goes onto acc
    case (state_q)
      ST_Y400: begin
        take = (func_q == FUNC_DATE2DN) ? YEARS_400 : DAYS_400Y;
        give = AccW'((func_q == FUNC_DATE2DN) ? DAYS_400Y : YEARS_400);
      end
      ST_Y100: begin
        take = (func_q == FUNC_DATE2DN) ? YEARS_100 : DAYS_100Y;
        give = AccW'((func_q == FUNC_DATE2DN) ? DAYS_100Y : YEARS_100);
      end
      ST_Y4: begin
        take = (func_q == FUNC_DATE2DN) ? YEARS_4 : DAYS_4Y;
        give = AccW'((func_q == FUNC_DATE2DN) ? DAYS_4Y : YEARS_4);
      end
      ST_Y1: begin
        take = (func_q == FUNC_DATE2DN) ? YEARS_1 : DAYS_1Y;
        give = AccW'((func_q == FUNC_DATE2DN) ? DAYS_1Y : YEARS_1);
      end
      ST_MON: begin
        take = DnW'(mlen_cur);
        give = '0;
      end
      ST_SUM: begin
        take = '0;
        give = AccW'(doy_q);
      end
      default: begin
        take = '0;
        give = '0;
      end
    endcase
    diff = {1'b0, r_q} - {1'b0, take};
    ge   = ~diff[DnW];
    sum  = acc_q + give;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          func_d = func_i;
          dn_d   = day_number_i;
          yr_d   = in_year_i;
          mo_d   = in_month_i;
          d_d    = in_day_i;
          c_d    = '0;
          q4_d   = '0;
          y1_d   = '0;
          if (func_i == FUNC_DN2DATE) begin
            if ((day_number_i == '0) || ({10'd0, day_number_i} > DN_LIMIT)) begin
              fin       = 1'b1;
              res_err_d = 1'b1;
              res_dn_d  = day_number_i;
            end else begin
              r_d     = day_number_i - 22'd1;
              acc_d   = AccW'(1);
              state_d = ST_Y400;
            end
          end else begin
            if ((in_year_i == '0) || ({3'd0, in_year_i} > MAX_YEAR_W) ||
                (in_month_i == '0) || (in_month_i > MON_DEC) || (in_day_i == '0)) begin
              fin       = 1'b1;
              res_err_d = 1'b1;
            end else begin
              r_d     = DnW'(in_year_i - 14'd1);
              acc_d   = '0;
              state_d = ST_Y400;
            end
          end
        end
      end
      ST_Y400: begin
        if (ge) begin
          r_d   = diff[DnW-1:0];
          acc_d = sum;
        end else begin
          state_d = ST_Y100;
        end
      end
      ST_Y100: begin
        // at most three centuries: the last day of a 400-year span stays
        if (ge && (c_q != 2'd3)) begin
          r_d   = diff[DnW-1:0];
          acc_d = sum;
          c_d   = c_q + 2'd1;
        end else begin
          state_d = ST_Y4;
        end
      end
      ST_Y4: begin
        if (ge) begin
          r_d   = diff[DnW-1:0];
          acc_d = sum;
          q4_d  = q4_q + 5'd1;
        end else begin
          state_d = ST_Y1;
        end
      end
      ST_Y1: begin
        if (ge && (y1_q != 2'd3)) begin
          r_d   = diff[DnW-1:0];
          acc_d = sum;
          y1_d  = y1_q + 2'd1;
        end else begin
          leap_d = leap_now;
          m_d    = 4'd1;
          if (func_q == FUNC_DN2DATE) begin
            doy_d   = r_q[DoyW-1:0] + 9'd1;
            state_d = ST_MON;
          end else if (d_q > month_len(mo_q, leap_now)) begin
            fin       = 1'b1;
            res_err_d = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            doy_d   = DoyW'(d_q);
            state_d = ST_MON;
          end
        end
      end
      ST_MON: begin
        if (func_q == FUNC_DN2DATE) begin
          if (ge && (m_q != MON_DEC)) begin
            r_d = diff[DnW-1:0];
            m_d = m_q + 4'd1;
          end else begin
            fin        = 1'b1;
            res_dn_d   = dn_q;
            res_yr_d   = acc_q[YrW-1:0];
            res_mo_d   = m_q;
            res_day_d  = r_q[DayW-1:0] + 5'd1;
            res_doy_d  = doy_q;
            res_leap_d = leap_q;
            state_d    = ST_IDLE;
          end
        end else begin
          if (m_q != mo_q) begin
            doy_d = doy_q + DoyW'(mlen_cur);
            m_d   = m_q + 4'd1;
          end else begin
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        fin     = 1'b1;
        state_d = ST_IDLE;
        if (sum > DN_MAX) begin
          res_err_d = 1'b1;
        end else begin
          res_dn_d   = sum[DnW-1:0];
          res_yr_d   = yr_q;
          res_mo_d   = mo_q;
          res_day_d  = d_q;
          res_doy_d  = doy_q;
          res_leap_d = leap_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    acc_q  <= acc_d;
    c_q    <= c_d;
    q4_q   <= q4_d;
    y1_q   <= y1_d;
    m_q    <= m_d;
    doy_q  <= doy_d;
    leap_q <= leap_d;
    func_q <= func_d;
    dn_q   <= dn_d;
    yr_q   <= yr_d;
    mo_q   <= mo_d;
    d_q    <= d_d;
    if (fin) begin
      res_dn_q   <= res_dn_d;
      res_yr_q   <= res_yr_d;
      res_mo_q   <= res_mo_d;
      res_day_q  <= res_day_d;
      res_doy_q  <= res_doy_d;
      res_leap_q <= res_leap_d;
      res_err_q  <= res_err_d;
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign out_day_number_o = res_dn_q;
  assign out_year_o       = res_yr_q;
  assign out_month_o      = res_mo_q;
  assign out_day_o        = res_day_q;
  assign day_of_year_o    = res_doy_q;
  assign is_leap_o        = res_leap_q;
  assign status_o         = res_err_q;

endmodule
`default_nettype wire

FILE: sim/day_number_date_converter_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// day_number_date_converter_test
// Self-checking bench for the day number / Gregorian date converter. A queue
// of requests (directed corners, then random dates and day numbers) feeds a
// start/busy driver. Each beat, in either direction, is predicted and
// checked field by field against the done_o strobe, in order.
// ----------------------------------------------------------------------------
module day_number_date_converter_test;
  import dndc_pkg::*;

  localparam int unsigned MaxYear     = 9999;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned MaxGap      = 19;
  localparam int unsigned TailCycles  = 120;
  localparam logic        STATUS_OK    = 1'b0;
  localparam logic        STATUS_RANGE = 1'b1;

  typedef struct {
    logic            func;
    logic [DnW-1:0]  dn;
    logic [YrW-1:0]  year;
    logic [MonW-1:0] month;
    logic [DayW-1:0] day;
    int unsigned     gap;
    bit              drain;   // hold off until all results are back
  } request_t;

  typedef struct {
    logic            func;
    logic [DnW-1:0]  dn;
    logic [YrW-1:0]  year;
    logic [MonW-1:0] month;
    logic [DayW-1:0] day;
    logic [DoyW-1:0] doy;
    logic            leap;
    logic            status;
  } conversion_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            start_i      = 1'b0;
  logic            func_i       = FUNC_DN2DATE;
  logic [DnW-1:0]  day_number_i = '0;
  logic [YrW-1:0]  in_year_i    = '0;
  logic [MonW-1:0] in_month_i   = '0;
  logic [DayW-1:0] in_day_i     = '0;
  logic            busy_o;
  logic            done_o;
  logic [DnW-1:0]  out_day_number_o;
  logic [YrW-1:0]  out_year_o;
  logic [MonW-1:0] out_month_o;
  logic [DayW-1:0] out_day_o;
  logic [DoyW-1:0] day_of_year_o;
  logic            is_leap_o;
  logic            status_o;

  day_number_date_converter #(
    .MAX_YEAR(MaxYear)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .day_number_i    (day_number_i),
    .in_year_i       (in_year_i),
    .in_month_i      (in_month_i),
    .in_day_i        (in_day_i),
    .done_o          (done_o),
    .out_day_number_o(out_day_number_o),
    .out_year_o      (out_year_o),
    .out_month_o     (out_month_o),
    .out_day_o       (out_day_o),
    .day_of_year_o   (day_of_year_o),
    .is_leap_o       (is_leap_o),
    .status_o        (status_o)
  );

  request_t    conversion_requests[$];
  conversion_t conversions_due[$];
  request_t    staged;
  request_t    on_bus;
  bit          staged_valid = 1'b0;
  int unsigned gap_left     = 0;
  int unsigned failures     = 0;
  int unsigned cycles       = 0;
  int unsigned to_date_seen = 0;
  int unsigned to_dn_seen   = 0;
  int unsigned rejects_seen = 0;

  // ---------------------------------------------------------------- calendar
  function automatic bit gregorian_leap(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      2:             len = gregorian_leap(y) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  function automatic int unsigned days_before(int unsigned y);
    int unsigned n;
    n = y - 1;
    return n * 365 + n / 4 - n / 100 + n / 400;
  endfunction

  function automatic conversion_t convert_calendar(request_t rq);
    conversion_t res;
    int unsigned n, r, c, q4, y1, year, m, doy, total;
    res.func   = rq.func;
    res.dn     = '0;
    res.year   = '0;
    res.month  = '0;
    res.day    = '0;
    res.doy    = '0;
    res.leap   = 1'b0;
    res.status = STATUS_OK;
    if (rq.func == FUNC_DN2DATE) begin
      res.dn = rq.dn;
      if (rq.dn == 0 || rq.dn > days_before(MaxYear + 1)) begin
        res.status = STATUS_RANGE;
      end else begin
        n  = rq.dn - 1;
        r  = n % 146097;
        c  = r / 36524;
        if (c > 3) c = 3;           // last day of a 400-year cycle
        r  = r - c * 36524;
        q4 = r / 1461;
        r  = r % 1461;
        y1 = r / 365;
        if (y1 > 3) y1 = 3;         // Dec 31 of a leap year
        r  = r - y1 * 365;
        year = (n / 146097) * 400 + c * 100 + q4 * 4 + y1 + 1;
        res.doy = DoyW'(r + 1);
        m = 1;
        while (m < 12 && r >= days_in_month(year, m)) begin
          r = r - days_in_month(year, m);
          m++;
        end
        res.year  = YrW'(year);
        res.month = MonW'(m);
        res.day   = DayW'(r + 1);
        res.leap  = gregorian_leap(year);
      end
    end else begin
      year = 32'(rq.year);
      if (year == 0 || year > MaxYear || rq.month == 0 || rq.month > MON_DEC ||
          rq.day == 0 || rq.day > days_in_month(year, rq.month)) begin
        res.status = STATUS_RANGE;
      end else begin
        doy = 32'(rq.day);
        for (m = 1; m < rq.month; m++) doy += days_in_month(year, m);
        total = days_before(year) + doy;
        if (total > 32'h3FFFFF) begin
          res.status = STATUS_RANGE;
        end else begin
          res.dn    = DnW'(total);
          res.year  = rq.year;
          res.month = rq.month;
          res.day   = rq.day;
          res.doy   = DoyW'(doy);
          res.leap  = gregorian_leap(year);
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------- stimulus
  task automatic add_request(logic func, int unsigned dn, int unsigned year,
                             int unsigned month, int unsigned day, int unsigned gap,
                             bit drain);
    request_t rq;
    rq.func  = func;
    rq.dn    = DnW'(dn);
    rq.year  = YrW'(year);
    rq.month = MonW'(month);
    rq.day   = DayW'(day);
    rq.gap   = gap;
    rq.drain = drain;
    conversion_requests.push_back(rq);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int unsigned pick, year, month, day, dn, gap, len;
    bit          no_idle;
    no_idle = 1'b0;

    // day number to date: range ends, cycle boundaries, leap days
    add_request(FUNC_DN2DATE, 0,        0, 0, 0, 0, 0);
    add_request(FUNC_DN2DATE, 1,        0, 0, 0, 3, 0);
    add_request(FUNC_DN2DATE, 3652059,  0, 0, 0, 0, 0);
    add_request(FUNC_DN2DATE, 3652060,  0, 0, 0, 0, 0);
    add_request(FUNC_DN2DATE, 22'h3FFFFF, 0, 0, 0, 7, 0);
    add_request(FUNC_DN2DATE, 1461,     0, 0, 0, 0, 0);
    add_request(FUNC_DN2DATE, 36524,    0, 0, 0, 0, 0);
    add_request(FUNC_DN2DATE, 36525,    0, 0, 0, 1, 0);
    add_request(FUNC_DN2DATE, 146097,   0, 0, 0, 0, 0);
    add_request(FUNC_DN2DATE, 146098,   0, 0, 0, 0, 0);
    add_request(FUNC_DN2DATE, 730179,   0, 0, 0, 2, 0);  // 2000-02-29
    add_request(FUNC_DN2DATE, 693655,   0, 0, 0, 0, 0);  // 1900-03-01
    // date to day number: bad fields, leap rules, extremes
    add_request(FUNC_DATE2DN, 22'h3FFFFF, 1, 1, 1, 0, 0);
    add_request(FUNC_DATE2DN, 0, 9999, 12, 31, 0, 0);
    add_request(FUNC_DATE2DN, 0, 0,     6, 15, 0, 0);
    add_request(FUNC_DATE2DN, 0, 10000, 1,  1, 4, 0);
    add_request(FUNC_DATE2DN, 0, 14'h3FFF, 15, 31, 0, 0);
    add_request(FUNC_DATE2DN, 0, 2024,  0, 10, 0, 0);
    add_request(FUNC_DATE2DN, 0, 2024, 13, 10, 0, 0);
    add_request(FUNC_DATE2DN, 0, 2024,  5,  0, 0, 0);
    add_request(FUNC_DATE2DN, 0, 2023,  4, 31, 0, 0);
    add_request(FUNC_DATE2DN, 0, 1900, MON_FEB, 29, 0, 0);
    add_request(FUNC_DATE2DN, 0, 2000, MON_FEB, 29, 9, 0);
    add_request(FUNC_DATE2DN, 0, 2004, MON_FEB, 29, 0, 0);
    add_request(FUNC_DATE2DN, 0, 2003, MON_FEB, 29, 0, 0);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(3, 0) == 0);
      gap  = no_idle ? 0 : $urandom_range(MaxGap, 0);
      pick = $urandom_range(99, 0);
      dn    = $urandom & 32'h3FFFFF;
      year  = $urandom & 32'h3FFF;
      month = $urandom & 32'hF;
      day   = $urandom & 32'h1F;
      if ($urandom_range(1, 0) == 0) begin
        if (pick < 65)      dn = $urandom_range(3652059, 1);
        else if (pick < 75) dn = $urandom_range(3000, 1);
        else if (pick < 85) dn = $urandom_range(3652059, 3650000);
        else if (pick < 90) dn = $urandom_range(32'h3FFFFF, 3652060);
        add_request(FUNC_DN2DATE, dn, year, month, day, gap, i % 150 == 0);
      end else begin
        if (pick < 85) begin
          year  = (pick < 15) ? $urandom_range(99, 1) * 100 : $urandom_range(MaxYear, 1);
          month = $urandom_range(12, 1);
          len   = days_in_month(year, month);
          day   = (pick < 75) ? $urandom_range(len, 1) : len + 1;
          if (day > 31) day = $urandom_range(31, 1);
        end
        add_request(FUNC_DATE2DN, dn, year, month, day, gap, i % 150 == 0);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (conversion_requests.size() != 0 || staged_valid || start_i ||
           conversions_due.size() != 0);
    repeat (TailCycles) @(negedge clk_i);

    $display("Checked %0d date lookups and %0d day number lookups, %0d of them rejected.",
             to_date_seen, to_dn_seen, rejects_seen);
    $display("Directed corners, random calendar spread, idle gaps and drain pauses ran.");
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ----------------------------------------------------------------- driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      automatic logic next_start = start_i;
      if (start_i && !busy_o) begin
        conversions_due.push_back(convert_calendar(on_bus));
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (!staged_valid && conversion_requests.size() != 0) begin
          staged       = conversion_requests.pop_front();
          gap_left     = staged.gap;
          staged_valid = 1'b1;
        end
        if (staged_valid) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (!staged.drain || conversions_due.size() == 0) begin
            on_bus       = staged;
            staged_valid = 1'b0;
            next_start   = 1'b1;
            func_i       <= staged.func;
            day_number_i <= staged.dn;
            in_year_i    <= staged.year;
            in_month_i   <= staged.month;
            in_day_i     <= staged.day;
          end
        end
      end
      start_i <= next_start;
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (conversions_due.size() == 0) begin
        failures++;
        $display("%0t: result beat with nothing outstanding, day number %0d status %0d",
                 $time, out_day_number_o, status_o);
      end else begin
        automatic conversion_t want = conversions_due.pop_front();
        if (want.func == FUNC_DN2DATE) to_date_seen++;
        else to_dn_seen++;
        if (want.status == STATUS_RANGE) rejects_seen++;
        check_field("out_day_number", want.dn,     out_day_number_o);
        check_field("out_year",       want.year,   out_year_o);
        check_field("out_month",      want.month,  out_month_o);
        check_field("out_day",        want.day,    out_day_o);
        check_field("day_of_year",    want.doy,    day_of_year_o);
        check_field("is_leap",        want.leap,   is_leap_o);
        check_field("status",         want.status, status_o);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, conversions_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
`default_nettype wire
